// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared types and constants of the sync framed packet deframer.
// ----------------------------------------------------------------------------
package sfpd_pkg;

    localparam int IDX_W         = 17;
    localparam int QUEUE_DEPTH   = 4;

    // Stream byte codes
    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_V     = 8'h56;
    localparam logic [7:0] CHAR_S     = 8'h53;

    // Packet kinds
    localparam logic [1:0] KIND_VIDEO   = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    // One queue entry: a single result, or the held-back first type byte paired with the second
    typedef struct packed {
        logic [7:0]       byte_a;
        logic [7:0]       byte_b;
        logic [IDX_W-1:0] idx;
        logic [1:0]       kind;
        logic             last;
        logic             pair;
    } t_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/sfpd_front.sv =====
// ----------------------------------------------------------------------------
// sfpd_front
// Sync hunt, packet type classification and length tracking; one byte per
// cycle while the queue has room, pushes finished results into the queue.
// ----------------------------------------------------------------------------
module sfpd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_ready,
    input  sfpd_pkg::t_q_stat             i_q_stat,
    output logic                          o_push,
    output sfpd_pkg::t_entry              o_entry
);

    typedef enum logic [7:0] {
        PH_SYNC0   = 8'b0000_0001,
        PH_SYNC1   = 8'b0000_0010,
        PH_SYNC2   = 8'b0000_0100,
        PH_SYNC3   = 8'b0000_1000,
        PH_TYPE    = 8'b0001_0000,
        PH_HEADER  = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } t_phase;

    localparam int W = sfpd_pkg::IDX_W;

    t_phase         r_phase, n_phase;
    logic [W-1:0]   r_byte_count, n_byte_count;
    logic [1:0]     r_kind, n_kind;
    logic [W-1:0]   r_payload_len, n_payload_len;
    logic [7:0]     r_held_first, n_held_first;
    logic [7:0]     r_held_high, n_held_high;

    logic           accept;
    logic [W-1:0]   bc_inc;
    logic [W-1:0]   len_calc;
    logic [W-1:0]   tail_len;
    logic [7:0]     b;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign b       = i_data_byte;
    assign bc_inc  = r_byte_count + W'(1);

    // Tail is one byte longer for a section whose payload end index is odd
    assign tail_len = (r_kind == sfpd_pkg::KIND_SECTION && r_payload_len[0]) ? W'(5) : W'(4);

    // Per-byte state update and result build
    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_kind        = r_kind;
        n_payload_len = r_payload_len;
        n_held_first  = r_held_first;
        n_held_high   = r_held_high;
        len_calc      = r_payload_len;
        o_push        = 1'b0;
        o_entry.byte_a = b;
        o_entry.byte_b = b;
        o_entry.idx    = r_byte_count;
        o_entry.kind   = r_kind;
        o_entry.last   = 1'b0;
        o_entry.pair   = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_SYNC0: begin
                    n_phase = (b == sfpd_pkg::SYNC_BYTE) ? PH_SYNC1 : PH_SYNC0;
                end
                PH_SYNC1: begin
                    n_phase = (b == sfpd_pkg::SYNC_BYTE) ? PH_SYNC2 : PH_SYNC0;
                end
                PH_SYNC2: begin
                    n_phase = (b == sfpd_pkg::SYNC_BYTE) ? PH_SYNC3 : PH_SYNC0;
                end
                PH_SYNC3: begin
                    if (b == sfpd_pkg::ZERO_BYTE) begin
                        n_phase      = PH_TYPE;
                        n_byte_count = '0;
                    end else if (b != sfpd_pkg::SYNC_BYTE) begin
                        n_phase = PH_SYNC0;
                    end
                end
                PH_TYPE: begin
                    if (r_byte_count == '0) begin
                        // first type byte is held back
                        n_held_first = b;
                        n_byte_count = W'(1);
                    end else begin
                        o_push         = 1'b1;
                        o_entry.byte_a = r_held_first;
                        o_entry.idx    = '0;
                        o_entry.pair   = 1'b1;
                        n_byte_count   = W'(2);
                        if (r_held_first == sfpd_pkg::CHAR_A && b == sfpd_pkg::CHAR_V) begin
                            n_kind  = sfpd_pkg::KIND_VIDEO;
                            n_phase = PH_HEADER;
                        end else if (r_held_first == sfpd_pkg::CHAR_S) begin
                            n_kind  = sfpd_pkg::KIND_SECTION;
                            n_phase = PH_HEADER;
                        end else if (r_held_first == sfpd_pkg::ZERO_BYTE) begin
                            n_kind        = sfpd_pkg::KIND_EMPTY;
                            n_payload_len = W'(2);
                            n_phase       = PH_TAIL;
                        end else begin
                            // unknown type: drop both bytes, hunt again
                            o_push       = 1'b0;
                            n_byte_count = r_byte_count;
                            n_phase      = PH_SYNC0;
                        end
                        o_entry.kind = n_kind;
                    end
                end
                PH_HEADER: begin
                    o_push       = 1'b1;
                    n_byte_count = bc_inc;
                    if (r_kind == sfpd_pkg::KIND_VIDEO) begin
                        len_calc = W'(8) + W'({r_held_high, b});
                        if (bc_inc == W'(7)) begin
                            n_held_high = b;
                        end else if (bc_inc == W'(8)) begin
                            n_payload_len = len_calc;
                            n_phase       = (bc_inc == len_calc) ? PH_TAIL : PH_PAYLOAD;
                        end
                    end else if (r_kind == sfpd_pkg::KIND_SECTION) begin
                        len_calc = W'(5) + W'({r_held_high[3:0], b});
                        if (bc_inc == W'(4)) begin
                            n_held_high = b;
                        end else if (bc_inc == W'(5)) begin
                            n_payload_len = len_calc;
                            n_phase       = (bc_inc == len_calc) ? PH_TAIL : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_push       = 1'b1;
                    n_byte_count = bc_inc;
                    if (bc_inc >= r_payload_len) begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    o_push       = 1'b1;
                    n_byte_count = bc_inc;
                    if (bc_inc >= r_payload_len + tail_len) begin
                        o_entry.last = 1'b1;
                        n_phase      = PH_SYNC0;
                    end
                end
                default: begin
                    n_phase = PH_SYNC0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC0;
            r_byte_count  <= '0;
            r_kind        <= '0;
            r_payload_len <= '0;
            r_held_first  <= '0;
            r_held_high   <= '0;
        end else begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_kind        <= n_kind;
            r_payload_len <= n_payload_len;
            r_held_first  <= n_held_first;
            r_held_high   <= n_held_high;
        end
    end

endmodule

// ===== sv/sfpd_queue.sv =====
// ----------------------------------------------------------------------------
// sfpd_queue
// Small FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module sfpd_queue #(
    parameter int DEPTH = sfpd_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfpd_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output sfpd_pkg::t_entry     o_head,
    output sfpd_pkg::t_q_stat    o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfpd_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/sfpd_back.sv =====
// ----------------------------------------------------------------------------
// sfpd_back
// Output stage: splits type-pair entries into two results and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module sfpd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfpd_pkg::t_entry              i_head,
    input  sfpd_pkg::t_q_stat             i_q_stat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_packet_byte,
    output logic [sfpd_pkg::IDX_W-1:0]    o_byte_index,
    output logic [1:0]                    o_packet_kind,
    output logic                          o_last
);

    localparam int W = sfpd_pkg::IDX_W;

    logic           r_valid;
    logic           r_half;
    logic [7:0]     r_byte;
    logic [W-1:0]   r_idx;
    logic [1:0]     r_kind;
    logic           r_last;
    logic           load;

    // Load a new result when the output register is free or being drained
    assign load  = !i_q_stat.empty && (!r_valid || i_ready);
    // A pair entry leaves the queue only with its second byte
    assign o_pop = load && (!i_head.pair || r_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= i_head.pair && !r_half;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_half ? i_head.byte_b : i_head.byte_a;
            r_idx  <= r_half ? W'(1) : i_head.idx;
            r_kind <= i_head.kind;
            r_last <= i_head.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_packet_byte = r_byte;
    assign o_byte_index  = r_idx;
    assign o_packet_kind = r_kind;
    assign o_last        = r_last;

endmodule

// ===== sv/sync_framed_packet_deframer_core.sv =====
// Sync framed packet deframer. Takes one stream byte per cycle and, after the
// sync pattern AA AA AA (more AA allowed) 00, emits every packet byte with its
// index, kind (video, section, empty) and a last flag. Input accepts one byte
// per cycle whenever the result queue (QUEUE_DEPTH entries) has room; results
// leave at one per cycle from a registered output while i_ready is high. The
// two packet type bytes come out as one queue entry split into two results;
// the queue absorbs the extra output transfer. With an empty queue, a result
// is written into the queue and then loaded into the output register.
// ----------------------------------------------------------------------------
// sync_framed_packet_deframer_core
// Top level: parser front end, result queue and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sync_framed_packet_deframer_core #(
    parameter int QUEUE_DEPTH = sfpd_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_packet_byte,
    output logic [sfpd_pkg::IDX_W-1:0]    o_byte_index,
    output logic [1:0]                    o_packet_kind,
    output logic                          o_last
);

    sfpd_pkg::t_q_stat  q_stat;
    sfpd_pkg::t_entry   push_entry;
    sfpd_pkg::t_entry   head_entry;
    logic               push;
    logic               pop;

    sfpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_ready     (o_ready),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    sfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_stat  (q_stat)
    );

    sfpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_entry),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_packet_byte (o_packet_byte),
        .o_byte_index  (o_byte_index),
        .o_packet_kind (o_packet_kind),
        .o_last        (o_last)
    );

    // Queue never overflows or underflows
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push, !q_stat.full)
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, pop, !q_stat.empty)
    // A push into an empty queue is visible next cycle
    `ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && q_stat.empty, !q_stat.empty)
    // Shortest packet (empty) ends at index 5
    `ASSERT_IMPL(a_last_min_index, i_clk, i_rst_n, o_valid && o_last,
                 o_byte_index >= sfpd_pkg::IDX_W'(5))

endmodule
